@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent check forms, clocked on clk, quiet while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASG_CHECK_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASG_CHECK_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/asg_pkg.sv @@
// ----------------------------------------------------------------------------
// asg_pkg
// Types, codes and helpers shared by the SGR attribute encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package asg_pkg;

  localparam int ATTR_W    = 18;
  localparam int BYTE_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int TAG_BIT   = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_COLORS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OPTIMIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT  = 2'd2;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 18'd7;

  // parameter tokens of one sequence, in emission order
  localparam int TOK_N = 9;
  localparam int TOK_W = $clog2(TOK_N);
  localparam logic [TOK_W-1:0] TK_HDR = 4'd0;
  localparam logic [TOK_W-1:0] TK_RST = 4'd1;
  localparam logic [TOK_W-1:0] TK_B1  = 4'd2;
  localparam logic [TOK_W-1:0] TK_K5  = 4'd3;
  localparam logic [TOK_W-1:0] TK_B22 = 4'd4;
  localparam logic [TOK_W-1:0] TK_K25 = 4'd5;
  localparam logic [TOK_W-1:0] TK_BG  = 4'd6;
  localparam logic [TOK_W-1:0] TK_FG  = 4'd7;
  localparam logic [TOK_W-1:0] TK_END = 4'd8;

  // longest token: separator, five-byte extended prefix, three digits
  localparam int SEQ_MAX = 9;
  localparam int SEQ_CW  = $clog2(SEQ_MAX + 1);

  localparam logic [BYTE_W-1:0] CH_ESC   = 8'h1B;
  localparam logic [BYTE_W-1:0] CH_LBR   = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3B;
  localparam logic [BYTE_W-1:0] CH_M     = 8'h6D;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_THREE = 8'h33;
  localparam logic [BYTE_W-1:0] CH_FOUR  = 8'h34;
  localparam logic [BYTE_W-1:0] CH_FIVE  = 8'h35;
  localparam logic [BYTE_W-1:0] CH_EIGHT = 8'h38;

  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // one colour/number parameter, already in decimal digits
  typedef struct packed {
    logic       ext;
    logic [1:0] nd;
    logic [3:0] d2;
    logic [3:0] d1;
    logic [3:0] d0;
  } col_t;

  typedef struct packed {
    logic [TOK_N-1:0] mask;
    col_t             bg;
    col_t             fg;
  } desc_t;

  typedef struct packed {
    logic              colors;
    logic              optimize;
    logic [ATTR_W-1:0] dflt;
  } cfg_t;

  localparam col_t COL_0  = col_t'{1'b0, 2'd1, 4'd0, 4'd0, 4'd0};
  localparam col_t COL_1  = col_t'{1'b0, 2'd1, 4'd0, 4'd0, 4'd1};
  localparam col_t COL_5  = col_t'{1'b0, 2'd1, 4'd0, 4'd0, 4'd5};
  localparam col_t COL_22 = col_t'{1'b0, 2'd2, 4'd0, 4'd2, 4'd2};
  localparam col_t COL_25 = col_t'{1'b0, 2'd2, 4'd0, 4'd2, 4'd5};

  function automatic logic [2:0] dos_swap(input logic [2:0] c);
    logic [2:0] r;
    case (c)
      3'd0:    r = 3'd0;
      3'd1:    r = 3'd4;
      3'd2:    r = 3'd2;
      3'd3:    r = 3'd6;
      3'd4:    r = 3'd1;
      3'd5:    r = 3'd5;
      3'd6:    r = 3'd3;
      default: r = 3'd7;
    endcase
    return r;
  endfunction

  // 8-bit value to decimal digits; tens via x*205>>11, exact below 1029
  function automatic col_t to_col(input logic [7:0] v, input logic ext);
    col_t        c;
    logic [6:0]  r;
    logic [14:0] p;
    logic [3:0]  t;
    logic [7:0]  t10;
    c.ext = ext;
    if (v >= 8'd200) begin
      c.d2 = 4'd2;
      r    = 7'(v - 8'd200);
    end else if (v >= 8'd100) begin
      c.d2 = 4'd1;
      r    = 7'(v - 8'd100);
    end else begin
      c.d2 = 4'd0;
      r    = v[6:0];
    end
    p    = 15'(r) * 15'd205;
    t    = p[14:11];
    t10  = 8'(t) * 8'd10;
    c.d1 = t;
    c.d0 = 4'({1'b0, r} - t10);
    c.nd = (v >= 8'd100) ? 2'd3 : ((v >= 8'd10) ? 2'd2 : 2'd1);
    return c;
  endfunction

endpackage

`default_nettype wire

@@ src/asg_front.sv @@
// ----------------------------------------------------------------------------
// asg_front
// Takes attribute words, compares with the previous one and works out which
// SGR parameters a sequence needs; pushes one descriptor per sequence.
// ----------------------------------------------------------------------------
`default_nettype none

module asg_front import asg_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [ATTR_W-1:0] in_new_attr,
  input  wire cfg_t              cfg,
  input  wire logic              q_ready,
  output logic                   q_push,
  output desc_t                  q_desc
);

  logic [ATTR_W-1:0] prev_r, prev_nxt;
  logic              acc;
  logic              nb, ni, ob, oi, ob_e, oi_e;
  logic [7:0]        nbg, nfg, obg, ofg, obg_e, ofg_e;
  logic [TOK_N-1:0]  mask;

  function automatic logic [7:0] bg_of(input logic [ATTR_W-1:0] a);
    return a[TAG_BIT] ? a[16:9] : {5'b0, a[6:4]};
  endfunction

  function automatic logic [7:0] fg_of(input logic [ATTR_W-1:0] a);
    return a[TAG_BIT] ? a[7:0] : {5'b0, a[2:0]};
  endfunction

  function automatic logic bold_of(input logic [ATTR_W-1:0] a);
    return a[TAG_BIT] ? a[17] : a[3];
  endfunction

  function automatic logic blink_of(input logic [ATTR_W-1:0] a);
    return a[TAG_BIT] ? 1'b0 : a[7];
  endfunction

  // palette number for a colour field, plain or 256-colour form
  function automatic col_t col_num(input logic tag, input logic [7:0] v,
                                   input logic [7:0] low, input logic [7:0] high);
    logic [7:0] n;
    logic       e;
    if (tag) begin
      if (v < 8'd16) begin
        e = 1'b0;
        n = 8'(v[2:0]) + (v[3] ? high : low);
      end else begin
        e = 1'b1;
        n = v;
      end
    end else begin
      e = 1'b0;
      n = low + 8'(dos_swap(v[2:0]));
    end
    return to_col(n, e);
  endfunction

  assign nb  = blink_of(in_new_attr);
  assign ni  = bold_of(in_new_attr);
  assign nbg = bg_of(in_new_attr);
  assign nfg = fg_of(in_new_attr);
  assign ob  = blink_of(prev_r);
  assign oi  = bold_of(prev_r);
  assign obg = bg_of(prev_r);
  assign ofg = fg_of(prev_r);

  always_comb begin
    mask         = '0;
    mask[TK_HDR] = 1'b1;
    mask[TK_END] = 1'b1;
    ob_e  = ob;
    oi_e  = oi;
    obg_e = obg;
    ofg_e = ofg;
    if (in_new_attr != cfg.dflt) begin
      if (cfg.optimize) begin
        // flag and colour both change: cheaper to reset first
        if (((ob != nb) || (oi != ni)) && ((obg != nbg) || (ofg != nfg))) begin
          mask[TK_RST] = 1'b1;
          ob_e  = 1'b0;
          oi_e  = 1'b0;
          obg_e = bg_of(cfg.dflt);
          ofg_e = fg_of(cfg.dflt);
        end
        mask[TK_B1]  = ni && !oi_e;
        mask[TK_K5]  = nb && !ob_e;
        mask[TK_B22] = !ni && oi_e;
        mask[TK_K25] = !nb && ob_e;
        mask[TK_BG]  = nbg != obg_e;
        mask[TK_FG]  = nfg != ofg_e;
      end else begin
        mask[TK_RST] = 1'b1;
        mask[TK_B1]  = ni;
        mask[TK_K5]  = nb;
        mask[TK_BG]  = 1'b1;
        mask[TK_FG]  = 1'b1;
      end
    end
  end

  assign q_desc.mask = mask;
  assign q_desc.bg   = col_num(in_new_attr[TAG_BIT], nbg, 8'd40, 8'd100);
  assign q_desc.fg   = col_num(in_new_attr[TAG_BIT], nfg, 8'd30, 8'd90);

  assign in_ready = q_ready;
  assign acc      = in_valid && q_ready;
  assign q_push   = acc && cfg.colors && (in_new_attr != prev_r);
  assign prev_nxt = acc ? in_new_attr : prev_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= ATTR_RESET;
    end else begin
      prev_r <= prev_nxt;
    end
  end

endmodule

`default_nettype wire

@@ src/asg_queue.sv @@
// ----------------------------------------------------------------------------
// asg_queue
// Small descriptor FIFO between the classifier and the byte generator.
// ----------------------------------------------------------------------------
`default_nettype none

module asg_queue import asg_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire desc_t push_data,
  output logic       ready,
  input  wire logic  pop,
  output logic       valid,
  output desc_t      head
);

  desc_t            mem_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]   cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign ready   = cnt_r != QCW'(QDEPTH);
  assign valid   = cnt_r != '0;
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && ready;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_r + QAW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_r + QAW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

@@ src/asg_back.sv @@
// ----------------------------------------------------------------------------
// asg_back
// Walks the tokens of one descriptor and sends the sequence a byte at a time
// through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module asg_back import asg_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  input  wire desc_t             q_head,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [BYTE_W-1:0]      out_byte,
  output logic                   out_last_byte
);

  typedef struct packed {
    logic [SEQ_MAX-1:0][BYTE_W-1:0] b;
    logic [SEQ_CW-1:0]              len;
  } tokb_t;

  logic [TOK_N-1:0]               pend_r, pend_nxt;
  desc_t                          cur_r, cur_nxt;
  logic [SEQ_MAX-1:0][BYTE_W-1:0] buf_r, buf_nxt;
  logic [SEQ_CW-1:0]              cnt_r, cnt_nxt;
  logic                           sep_r, sep_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]              out_byte_r, out_byte_nxt;
  logic                           out_last_r, out_last_nxt;
  logic [TOK_W-1:0]               tok;
  logic                           can_out;
  tokb_t                          tb;

  function automatic tokb_t tok_bytes(input logic [TOK_W-1:0] t, input logic sep,
                                      input desc_t d);
    tokb_t             r;
    col_t              c;
    logic [SEQ_CW-1:0] n;
    logic [BYTE_W-1:0] lead;
    r.b  = '0;
    n    = '0;
    c    = COL_0;
    lead = CH_FOUR;
    case (t)
      TK_HDR: begin
        r.b[0] = CH_ESC;
        r.b[1] = CH_LBR;
        n      = SEQ_CW'(2);
      end
      TK_END: begin
        r.b[0] = CH_M;
        n      = SEQ_CW'(1);
      end
      default: begin
        case (t)
          TK_RST:  c = COL_0;
          TK_B1:   c = COL_1;
          TK_K5:   c = COL_5;
          TK_B22:  c = COL_22;
          TK_K25:  c = COL_25;
          TK_BG: begin
            c    = d.bg;
            lead = CH_FOUR;
          end
          TK_FG: begin
            c    = d.fg;
            lead = CH_THREE;
          end
          default: c = COL_0;
        endcase
        if (sep) begin
          r.b[n] = CH_SEMI;
          n      = n + SEQ_CW'(1);
        end
        // "48;5;" / "38;5;" before a full palette index
        if (c.ext) begin
          r.b[n] = lead;
          n      = n + SEQ_CW'(1);
          r.b[n] = CH_EIGHT;
          n      = n + SEQ_CW'(1);
          r.b[n] = CH_SEMI;
          n      = n + SEQ_CW'(1);
          r.b[n] = CH_FIVE;
          n      = n + SEQ_CW'(1);
          r.b[n] = CH_SEMI;
          n      = n + SEQ_CW'(1);
        end
        if (c.nd == 2'd3) begin
          r.b[n] = CH_ZERO + BYTE_W'(c.d2);
          n      = n + SEQ_CW'(1);
        end
        if (c.nd != 2'd1) begin
          r.b[n] = CH_ZERO + BYTE_W'(c.d1);
          n      = n + SEQ_CW'(1);
        end
        r.b[n] = CH_ZERO + BYTE_W'(c.d0);
        n      = n + SEQ_CW'(1);
      end
    endcase
    r.len = n;
    return r;
  endfunction

  // lowest pending token goes first
  always_comb begin
    tok = '0;
    for (int i = TOK_N - 1; i >= 0; i--) begin
      if (pend_r[i]) begin
        tok = TOK_W'(i);
      end
    end
  end

  assign tb      = tok_bytes(tok, sep_r, cur_r);
  assign can_out = !out_valid_r || out_ready;

  always_comb begin
    pend_nxt      = pend_r;
    cur_nxt       = cur_r;
    buf_nxt       = buf_r;
    cnt_nxt       = cnt_r;
    sep_nxt       = sep_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    q_pop         = 1'b0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cnt_r != '0) begin
      if (can_out) begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = buf_r[0];
        out_last_nxt  = 1'b0;
        buf_nxt       = buf_r >> BYTE_W;
        cnt_nxt       = cnt_r - SEQ_CW'(1);
      end
    end else if (pend_r != '0) begin
      if (can_out) begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = tb.b[0];
        out_last_nxt  = tok == TK_END;
        buf_nxt       = tb.b >> BYTE_W;
        cnt_nxt       = tb.len - SEQ_CW'(1);
        pend_nxt      = pend_r & ~(TOK_N'(1) << tok);
        if (tok != TK_HDR && tok != TK_END) begin
          sep_nxt = 1'b1;
        end
      end
    end else if (q_valid) begin
      q_pop    = 1'b1;
      cur_nxt  = q_head;
      pend_nxt = q_head.mask;
      sep_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      cnt_r       <= '0;
      sep_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      cnt_r       <= cnt_nxt;
      sep_r       <= sep_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    buf_r      <= buf_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_last_byte = out_last_r;

endmodule

`default_nettype wire

@@ src/ansi_sgr_attribute_encoder.sv @@
// ----------------------------------------------------------------------------
// ansi_sgr_attribute_encoder
// Turns text attribute changes into ANSI SGR escape sequences, byte by byte.
// ----------------------------------------------------------------------------
// Each accepted attribute word is compared with the previous one at the input
// side, combinationally; one that needs no sequence (unchanged, or colours
// disabled) queues nothing. A sequence of n bytes (3 to 24) has the byte
// generator fetch its descriptor from the two-entry queue, then send one byte
// per cycle through the output register while out_ready does not hold it back.
// Input is taken while the queue has room, so up to two sequences may be
// waiting behind the one being sent. Configuration writes are taken in every cycle.
`default_nettype none
`include "assert_macros.svh"

module ansi_sgr_attribute_encoder import asg_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [ATTR_W-1:0]    in_new_attr,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [BYTE_W-1:0]         out_byte,
  output logic                      out_last_byte,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ATTR_W-1:0]    cfg_data
);

  logic              colors_r, colors_nxt;
  logic              optimize_r, optimize_nxt;
  logic [ATTR_W-1:0] dflt_r, dflt_nxt;
  cfg_t              cfg;
  logic              q_push, q_ready, q_pop, q_valid;
  desc_t             q_desc, q_head;
  logic              last_xfer;

  assign cfg_ready = 1'b1;

  always_comb begin
    colors_nxt   = colors_r;
    optimize_nxt = optimize_r;
    dflt_nxt     = dflt_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_COLORS:   colors_nxt   = cfg_data[0];
        CFG_OPTIMIZE: optimize_nxt = cfg_data[0];
        CFG_DEFAULT:  dflt_nxt     = cfg_data;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      colors_r   <= 1'b1;
      optimize_r <= 1'b1;
      dflt_r     <= ATTR_RESET;
    end else begin
      colors_r   <= colors_nxt;
      optimize_r <= optimize_nxt;
      dflt_r     <= dflt_nxt;
    end
  end

  assign cfg.colors   = colors_r;
  assign cfg.optimize = optimize_r;
  assign cfg.dflt     = dflt_r;

  asg_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_new_attr (in_new_attr),
    .cfg         (cfg),
    .q_ready     (q_ready),
    .q_push      (q_push),
    .q_desc      (q_desc)
  );

  asg_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_desc),
    .ready     (q_ready),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  asg_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_last_byte (out_last_byte)
  );

  assign last_xfer = out_valid && out_ready && out_last_byte;

  // terminator of every sequence is 'm'
  `ASG_CHECK_NOW(a_last_is_m, out_valid && out_last_byte, out_byte == CH_M, "last byte is not m")

  // a new sequence always opens with ESC
  `ASG_CHECK_NEXT(a_open_esc, last_xfer, !out_valid || out_byte == CH_ESC, "no ESC after m")

  `ASG_CHECK_NOW(a_quiet_off, !colors_r, !q_push, "sequence queued with colours off")

endmodule

`default_nettype wire
